>>> src/ped_pkg.sv
// Shared types and constants of the peak envelope decimator.
`default_nettype none
package ped_pkg;

	// Default number of buckets a waveform is split into.
	localparam int PEAK_BUCKETS_DEF = 32768;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_SAMPLES = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS      = 8'd1;

	// One stereo sample frame, Q1.15 per channel.
	typedef struct packed {
		logic signed [15:0] sample_left;
		logic signed [15:0] sample_right;
	} ped_in_t;

	// One completed bucket.
	typedef struct packed {
		logic [15:0]        bucket_number;
		logic [14:0]        left_max;
		logic signed [15:0] left_min;
		logic [14:0]        right_max;
		logic signed [15:0] right_min;
		logic               final_bucket;
	} ped_out_t;

	// One configuration register write.
	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [31:0]            data;
	} ped_cfg_t;

	// Write of the waveform length into the bucket tracker.
	typedef struct packed {
		logic        wr;
		logic [31:0] value;
	} ped_len_wr_t;

	// Status of the bucket tracker for the frame now being processed.
	typedef struct packed {
		logic        close;
		logic        last;
		logic [15:0] bucket;
	} ped_bkt_status_t;

	// Control of one channel's running peak tracker.
	typedef struct packed {
		logic upd;
		logic flush;
		logic clear;
	} ped_peak_ctl_t;

endpackage
`default_nettype wire

>>> src/ped_stream_if.sv
// Valid/ready channel interface used by the sample, result and configuration ports.
`default_nettype none
interface ped_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/ped_peak_track.sv
// Running maximum and minimum of one audio channel within the current bucket.
`default_nettype none
module ped_peak_track import ped_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ped_peak_ctl_t      ctl,
	input  wire logic signed [15:0] sample,
	output logic [14:0]             max_nxt,
	output logic signed [15:0]      min_nxt
);

	logic [14:0]        max_q;
	logic signed [15:0] min_q;

	// Peaks including the current sample; the maximum never drops below zero.
	always_comb begin
		max_nxt = max_q;
		min_nxt = min_q;
		if (ctl.upd) begin
			if (sample > $signed({1'b0, max_q})) begin
				max_nxt = sample[14:0];
			end
			if (sample < min_q) begin
				min_nxt = sample;
			end
		end
	end

	// Peaks restart at zero when a bucket closes or the length is rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			min_q <= '0;
		end else if (ctl.clear || ctl.flush) begin
			max_q <= '0;
			min_q <= '0;
		end else begin
			max_q <= max_nxt;
			min_q <= min_nxt;
		end
	end

endmodule
`default_nettype wire

>>> src/ped_bucket_track.sv
// Frame counter and remainder accumulator that find where each bucket ends.
`default_nettype none
module ped_bucket_track import ped_pkg::*; #(
	parameter int PEAK_BUCKETS = PEAK_BUCKETS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire ped_len_wr_t     len_wr,
	output ped_bkt_status_t      status
);

	localparam int BW = $clog2(PEAK_BUCKETS + 1);

	logic [31:0]   total_q;
	logic [31:0]   total_m1_q;
	logic [BW-1:0] buckets_q;
	logic [31:0]   fc_q;
	logic [15:0]   bucket_q;
	logic [31:0]   rem_q;

	logic [31:0]   total_eff;
	logic [32:0]   next_rem;
	logic          last;
	logic          close;

	// A length of zero acts as one.
	assign total_eff = (len_wr.value == '0) ? 32'd1 : len_wr.value;

	// The bucket closes when the accumulator reaches or passes the length or the waveform ends.
	assign next_rem = 33'(rem_q) + 33'(buckets_q);
	assign last     = fc_q >= total_m1_q;
	assign close    = last || (next_rem >= 33'(total_q));

	assign status.close  = close;
	assign status.last   = last;
	assign status.bucket = bucket_q;

	// Length registers, precomputed at write time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= 32'd1;
			total_m1_q <= '0;
			buckets_q  <= BW'(1);
		end else if (len_wr.wr) begin
			total_q    <= total_eff;
			total_m1_q <= total_eff - 32'd1;
			buckets_q  <= (33'(total_eff) < 33'(PEAK_BUCKETS)) ? BW'(total_eff)
				: BW'(PEAK_BUCKETS);
		end
	end

	// Frame and bucket counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q     <= '0;
			bucket_q <= '0;
			rem_q    <= '0;
		end else if (len_wr.wr) begin
			fc_q     <= '0;
			bucket_q <= '0;
			rem_q    <= '0;
		end else if (step) begin
			if (!close) begin
				rem_q <= next_rem[31:0];
				fc_q  <= fc_q + 32'd1;
			end else if (last) begin
				fc_q     <= '0;
				bucket_q <= '0;
				rem_q    <= '0;
			end else begin
				rem_q    <= 32'(next_rem - 33'(total_q));
				fc_q     <= fc_q + 32'd1;
				bucket_q <= bucket_q + 16'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// The accumulator always holds a remainder modulo the length.
	a_rem_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < total_q)
		else $error("bucket remainder reached the waveform length");

	// The final frame returns all counters to zero.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last && !len_wr.wr |=> fc_q == '0 && bucket_q == '0 && rem_q == '0)
		else $error("counters not cleared after the final frame");
`endif

endmodule
`default_nettype wire

>>> src/peak_envelope_decimator.sv
// Peak envelope decimator: min/max per bucket of a mono or stereo Q1.15 stream.
// A frame that closes a bucket is held in the input register, then its result in
// the result register. The throughput loop is the bucket accumulator add and compare.
// Throughput: one frame per cycle while the result register is free or being emptied.
// Reset: length one, mono, counters and running peaks at zero, no result pending.
`default_nettype none
module peak_envelope_decimator import ped_pkg::*; #(
	parameter int PEAK_BUCKETS = PEAK_BUCKETS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ped_stream_if.sink     samples,
	ped_stream_if.source   peaks,
	ped_stream_if.sink     cfg
);

	logic            valid_s1;
	ped_in_t         smp_s1;
	logic            res_valid_q;
	ped_out_t        res_q;
	logic            stereo_q;
	logic            adv;
	logic            cfg_wr;
	ped_len_wr_t     len_wr;
	ped_bkt_status_t bst;
	ped_peak_ctl_t   ctl_left;
	ped_peak_ctl_t   ctl_right;
	logic [14:0]     left_max;
	logic signed [15:0] left_min;
	logic [14:0]     right_max;
	logic signed [15:0] right_min;

	// The registered frame moves on when the result register is free or being emptied.
	assign adv           = valid_s1 && (!res_valid_q || peaks.ready);
	assign samples.ready = !valid_s1 || adv;

	// Configuration transactions are always taken.
	assign cfg.ready    = 1'b1;
	assign cfg_wr       = cfg.valid;
	assign len_wr.wr    = cfg_wr && (cfg.payload.index == REG_TOTAL_SAMPLES);
	assign len_wr.value = cfg.payload.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b0;
		end else if (cfg_wr && (cfg.payload.index == REG_CHANNELS)) begin
			stereo_q <= cfg.payload.data[1];
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.valid && samples.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			smp_s1 <= samples.payload;
		end
	end

	ped_bucket_track #(
		.PEAK_BUCKETS(PEAK_BUCKETS)
	) u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.len_wr (len_wr),
		.status (bst)
	);

	// Peak trackers; the right channel is frozen while mono.
	assign ctl_left.upd    = adv;
	assign ctl_left.flush  = adv && bst.close;
	assign ctl_left.clear  = len_wr.wr;
	assign ctl_right.upd   = adv && stereo_q;
	assign ctl_right.flush = adv && bst.close;
	assign ctl_right.clear = len_wr.wr;

	ped_peak_track u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_left),
		.sample  (smp_s1.sample_left),
		.max_nxt (left_max),
		.min_nxt (left_min)
	);

	ped_peak_track u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_right),
		.sample  (smp_s1.sample_right),
		.max_nxt (right_max),
		.min_nxt (right_min)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= bst.close;
		end else if (peaks.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && bst.close) begin
			res_q.bucket_number <= bst.bucket;
			res_q.left_max      <= left_max;
			res_q.left_min      <= left_min;
			res_q.right_max     <= stereo_q ? right_max : '0;
			res_q.right_min     <= stereo_q ? right_min : '0;
			res_q.final_bucket  <= bst.last;
		end
	end

	assign peaks.valid   = res_valid_q;
	assign peaks.payload = res_q;

`ifndef NO_ASSERTIONS
	// A frame that does not close its bucket leaves no result behind.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !bst.close |=> !res_valid_q)
		else $error("result produced by a frame inside a bucket");

	// An accepted frame is held in the input register on the next cycle.
	a_frame_registered: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> valid_s1)
		else $error("accepted frame lost before processing");

	// A closing frame always shows its result on the next cycle.
	a_close_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && bst.close |=> res_valid_q)
		else $error("closed bucket not emitted");

	// Minima never rise above zero.
	a_min_nonpositive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.left_min[15] || res_q.left_min == '0)
			&& (res_q.right_min[15] || res_q.right_min == '0))
		else $error("bucket minimum above zero");
`endif

endmodule
`default_nettype wire

>>> tb/peak_envelope_decimator_checker.sv
// Bucket peak predictor and result checker for the peak envelope decimator.
module peak_envelope_decimator_checker import ped_pkg::*; #(
	parameter int BUCKETS = PEAK_BUCKETS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	input  logic     sample_ready,
	input  ped_in_t  sample_frame,
	input  logic     peak_valid,
	input  logic     peak_ready,
	input  ped_out_t peak_item,
	input  logic     cfg_valid,
	input  logic     cfg_ready,
	input  ped_cfg_t cfg_write,
	input  logic     run_done,
	output int       error_count,
	output int       pending_count
);

	// Register copies.
	logic [31:0] len_reg;
	logic [1:0]  chan_reg;

	// Bucket tracker and running peaks.
	logic [31:0]        frame_idx;
	logic [15:0]        bucket_idx;
	logic [32:0]        remainder;
	logic signed [15:0] run_lmax, run_lmin, run_rmax, run_rmin;

	// Completed buckets waiting for the block to deliver them.
	ped_out_t bucket_queue[$];
	ped_out_t want;
	logic     leftover_flagged;

	task automatic report_failure(input string line);
		$display("ERROR: %s", line);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic signed [31:0] got,
		input logic signed [31:0] exp);
		if (got !== exp) begin
			report_failure($sformatf("bucket %0d: %s got %0d want %0d",
				want.bucket_number, name, got, exp));
		end
	endtask

	function automatic void clear_stream();
		frame_idx  = '0;
		bucket_idx = '0;
		remainder  = '0;
		run_lmax   = '0;
		run_lmin   = '0;
		run_rmax   = '0;
		run_rmin   = '0;
	endfunction

	// Fold one frame into the running peaks and close the bucket when its last frame is in.
	function automatic void track_frame(input ped_in_t f);
		logic [32:0] span, nbuckets, next_rem;
		logic        stereo, last;
		ped_out_t    closed;
		span     = (len_reg == 32'd0) ? 33'd1 : {1'b0, len_reg};
		nbuckets = (span < 33'(BUCKETS)) ? span : 33'(BUCKETS);
		stereo   = chan_reg[1];
		if (f.sample_left > run_lmax) run_lmax = f.sample_left;
		if (f.sample_left < run_lmin) run_lmin = f.sample_left;
		if (stereo) begin
			if (f.sample_right > run_rmax) run_rmax = f.sample_right;
			if (f.sample_right < run_rmin) run_rmin = f.sample_right;
		end
		last     = {1'b0, frame_idx} >= span - 33'd1;
		next_rem = remainder + nbuckets;
		if (!last && next_rem < span) begin
			remainder = next_rem;
			frame_idx = frame_idx + 32'd1;
			return;
		end
		closed.bucket_number = bucket_idx;
		closed.left_max      = run_lmax[14:0];
		closed.left_min      = run_lmin;
		closed.right_max     = stereo ? run_rmax[14:0] : '0;
		closed.right_min     = stereo ? run_rmin : '0;
		closed.final_bucket  = last;
		bucket_queue.push_back(closed);
		run_lmax = '0;
		run_lmin = '0;
		run_rmax = '0;
		run_rmin = '0;
		if (last) begin
			frame_idx  = '0;
			bucket_idx = '0;
			remainder  = '0;
		end else begin
			remainder  = next_rem - span;
			frame_idx  = frame_idx + 32'd1;
			bucket_idx = bucket_idx + 16'd1;
		end
	endfunction

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg  = 32'd1;
			chan_reg = 2'd1;
			clear_stream();
			bucket_queue.delete();
			leftover_flagged = 1'b0;
			error_count      = 0;
			pending_count    = 0;
		end else begin
			// Results are matched before this edge's frame can add a new expectation.
			if (peak_valid && peak_ready) begin
				if (bucket_queue.size() == 0) begin
					report_failure($sformatf("bucket %0d delivered with none expected",
						peak_item.bucket_number));
				end else begin
					want = bucket_queue.pop_front();
					check_field("bucket_number", peak_item.bucket_number, want.bucket_number);
					check_field("left_max", peak_item.left_max, want.left_max);
					check_field("left_min", peak_item.left_min, want.left_min);
					check_field("right_max", peak_item.right_max, want.right_max);
					check_field("right_min", peak_item.right_min, want.right_min);
					check_field("final_bucket", peak_item.final_bucket, want.final_bucket);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_write.index == REG_TOTAL_SAMPLES) begin
					len_reg = cfg_write.data;
					clear_stream();
				end else if (cfg_write.index == REG_CHANNELS) begin
					chan_reg = cfg_write.data[1:0];
				end
			end
			if (sample_valid && sample_ready) begin
				track_frame(sample_frame);
			end
			if (run_done && !leftover_flagged && bucket_queue.size() != 0) begin
				report_failure($sformatf("%0d buckets never delivered", bucket_queue.size()));
				leftover_flagged = 1'b1;
			end
			pending_count = bucket_queue.size();
		end
	end

endmodule

>>> tb/peak_envelope_decimator_tb.sv
// Stimulus, handshake pacing and verdict for the peak envelope decimator.
module peak_envelope_decimator_tb;
	import ped_pkg::*;

	localparam int MAX_GAP       = 8;
	localparam int LONG_STALL    = 200;
	localparam int DRAIN_CYCLES  = 4;
	localparam int RANDOM_FRAMES = 500;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hA5;
	localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic calm;
	logic hold_off_req;
	logic run_done;
	int   errors;
	int   pending;
	int   cycles = 0;
	int   frames_sent;

	ped_stream_if #(.payload_t(ped_in_t))  samples_ch ();
	ped_stream_if #(.payload_t(ped_out_t)) peaks_ch ();
	ped_stream_if #(.payload_t(ped_cfg_t)) cfg_ch ();

	peak_envelope_decimator #(
		.PEAK_BUCKETS(PEAK_BUCKETS_DEF)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.peaks  (peaks_ch),
		.cfg    (cfg_ch)
	);

	peak_envelope_decimator_checker #(
		.BUCKETS(PEAK_BUCKETS_DEF)
	) checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (samples_ch.valid),
		.sample_ready (samples_ch.ready),
		.sample_frame (samples_ch.payload),
		.peak_valid   (peaks_ch.valid),
		.peak_ready   (peaks_ch.ready),
		.peak_item    (peaks_ch.payload),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_write    (cfg_ch.payload),
		.run_done     (run_done),
		.error_count  (errors),
		.pending_count(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result receiver: random stalls, calm stretches, and one long hold-off on request.
	initial begin
		int unsigned gap;
		peaks_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (hold_off_req) begin
				gap          = LONG_STALL;
				hold_off_req = 1'b0;
			end
			@(negedge clk);
			if (gap != 0) begin
				peaks_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			peaks_ch.ready <= 1'b1;
			do @(posedge clk); while (!(peaks_ch.valid && peaks_ch.ready));
		end
	end

	function automatic ped_in_t make_frame(input logic [15:0] l, input logic [15:0] r);
		return '{sample_left: l, sample_right: r};
	endfunction

	// Mostly full-range samples, with extremes, near-zero and one-signed frames mixed in.
	function automatic ped_in_t draw_frame();
		ped_in_t     f;
		int unsigned style;
		style = $urandom_range(0, 9);
		f     = ped_in_t'($urandom);
		if (style == 0) begin
			f.sample_left  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			f.sample_right = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		end else if (style == 1) begin
			f.sample_left  = 16'(int'($urandom_range(0, 16)) - 8);
			f.sample_right = 16'(int'($urandom_range(0, 16)) - 8);
		end else if (style == 2) begin
			f.sample_left[15]  = 1'b0;
			f.sample_right[15] = 1'b0;
		end else if (style == 3) begin
			f.sample_left[15]  = 1'b1;
			f.sample_right[15] = 1'b1;
		end
		return f;
	endfunction

	task automatic send_frame(input ped_in_t f);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap != 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.payload <= f;
		samples_ch.valid   <= 1'b1;
		do @(posedge clk); while (!(samples_ch.valid && samples_ch.ready));
		frames_sent++;
	endtask

	task automatic run_frames(input int count);
		repeat (count) send_frame(draw_frame());
	endtask

	// Stop offering frames and wait until the block has nothing left in flight.
	task automatic settle();
		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] data);
		@(negedge clk);
		cfg_ch.payload <= '{index: index, data: data};
		cfg_ch.valid   <= 1'b1;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Main stimulus and verdict.
	initial begin
		int unsigned kind;
		logic [31:0] len;
		int          count;
		logic        first;
		arst_n             = 1'b0;
		calm               = 1'b0;
		hold_off_req       = 1'b0;
		run_done           = 1'b0;
		frames_sent        = 0;
		samples_ch.valid   = 1'b0;
		samples_ch.payload = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.payload     = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: length one, mono, so every frame is a final bucket.
		send_frame(make_frame(16'h7FFF, 16'h8000));
		send_frame(make_frame(16'h8000, 16'h7FFF));
		send_frame(make_frame(16'h0000, 16'h0000));
		settle();

		// A length of zero acts as one; channel code three acts as stereo.
		write_reg(REG_TOTAL_SAMPLES, 32'd0);
		write_reg(REG_CHANNELS, 32'd3);
		send_frame(make_frame(16'h1234, 16'hFFFF));
		send_frame(make_frame(16'hFFFF, 16'h7FFF));
		settle();

		// Channel code zero acts as mono; one extra frame wraps into a new waveform.
		write_reg(REG_CHANNELS, 32'd0);
		write_reg(REG_TOTAL_SAMPLES, 32'd4);
		send_frame(make_frame(16'h8000, 16'h8000));
		send_frame(make_frame(16'h7FFF, 16'h7FFF));
		send_frame(make_frame(16'h0001, 16'hFFFE));
		send_frame(make_frame(16'hC000, 16'h4000));
		send_frame(make_frame(16'h4000, 16'hC000));
		settle();

		// Three frames per bucket; switch to mono in the middle of a bucket.
		write_reg(REG_TOTAL_SAMPLES, 32'(3 * PEAK_BUCKETS_DEF));
		write_reg(REG_CHANNELS, 32'd2);
		send_frame(make_frame(16'h0100, 16'h8000));
		send_frame(make_frame(16'hFF00, 16'h7FFF));
		send_frame(make_frame(16'h0005, 16'h0005));
		send_frame(make_frame(16'h0007, 16'h7FFF));
		settle();
		write_reg(REG_CHANNELS, 32'd1);
		send_frame(make_frame(16'h8000, 16'h1111));
		send_frame(make_frame(16'h0003, 16'h2222));
		settle();

		// A write to an unknown index changes nothing.
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_frame(make_frame(16'h7FFF, 16'h0000));
		send_frame(make_frame(16'h0000, 16'h8000));
		settle();

		// Longest waveform: buckets far apart, nothing closes here.
		write_reg(REG_TOTAL_SAMPLES, LEN_MAX);
		send_frame(make_frame(16'h5A5A, 16'hA5A5));
		send_frame(make_frame(16'hA5A5, 16'h5A5A));
		send_frame(make_frame(16'h7FFF, 16'h8000));
		settle();

		// Random phases; the first one pairs a short waveform with a long receiver hold-off.
		frames_sent = 0;
		first       = 1'b1;
		while (frames_sent < RANDOM_FRAMES) begin
			kind  = first ? 0 : $urandom_range(0, 9);
			calm  = !first && ($urandom_range(0, 3) == 0);
			len   = 32'd1;
			count = 1;
			if (kind <= 3) begin
				len   = $urandom_range(1, 24);
				count = int'(len) * int'($urandom_range(1, 3)) + int'($urandom_range(0, 5));
			end else if (kind == 4) begin
				len   = $urandom_range(0, 3);
				count = int'($urandom_range(1, 12));
			end else if (kind <= 7) begin
				len   = 32'(PEAK_BUCKETS_DEF) + $urandom_range(0, 3 * PEAK_BUCKETS_DEF);
				count = int'($urandom_range(10, 50));
			end else if (kind == 8) begin
				len   = $urandom_range(0, 1) ? LEN_MAX : $urandom;
				count = int'($urandom_range(5, 20));
			end else begin
				// Keep the current waveform going, only the channel mode changes.
				count = int'($urandom_range(5, 30));
			end
			if (kind != 9) begin
				write_reg(REG_TOTAL_SAMPLES, len);
			end
			write_reg(REG_CHANNELS, ($urandom & ~32'h3) | 32'($urandom_range(0, 3)));
			if ($urandom_range(0, 7) == 0) begin
				write_reg(REG_UNUSED, $urandom);
			end
			if (first) begin
				hold_off_req = 1'b1;
				count        = 40;
			end
			run_frames(count);
			settle();
			first = 1'b0;
		end

		run_done = 1'b1;
		repeat (2) @(negedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
src/ped_pkg.sv
src/ped_stream_if.sv
src/ped_peak_track.sv
src/ped_bucket_track.sv
src/peak_envelope_decimator.sv
tb/peak_envelope_decimator_checker.sv
tb/peak_envelope_decimator_tb.sv
